>>> sv/i2cee_pkg.sv
// Shared types and constants of the I2C EEPROM byte access sequencer.
package i2cee_pkg;

  localparam int unsigned ADDR_BITS_DEF = 13;

  localparam logic [6:0]  DEV_ADDR_RST   = 7'h50;
  localparam logic [15:0] WAIT_LIMIT_RST = 16'd60000;
  localparam logic [9:0]  POLL_LIMIT_RST = 10'd1000;

  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RSTART    = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK = 8'h18;
  localparam logic [7:0] ST_SLA_W_NAK = 8'h20;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_SLA_R_ACK = 8'h40;
  localparam logic [7:0] ST_READ_NAK  = 8'h58;

  typedef enum logic [1:0] {
    CFG_DEV_ADDR   = 2'd0,
    CFG_WAIT_LIMIT = 2'd1,
    CFG_POLL_LIMIT = 2'd2,
    CFG_NONE       = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EVENT = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_BYTE  = 3'd2,
    ACT_READ  = 3'd3,
    ACT_STOP  = 3'd4
  } act_t;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_START     = 5'd1,
    PH_SLA_W     = 5'd2,
    PH_ADDR_HI   = 5'd3,
    PH_ADDR_LO   = 5'd4,
    PH_DATA      = 5'd5,
    PH_STOP_W    = 5'd6,
    PH_RSTART    = 5'd7,
    PH_SLA_R     = 5'd8,
    PH_READ      = 5'd9,
    PH_STOP_OK   = 5'd10,
    PH_STOP_FAIL = 5'd11,
    PH_P_START   = 5'd12,
    PH_P_SLA     = 5'd13,
    PH_P_RETRY   = 5'd14
  } phase_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] mem_address;
    logic [7:0]  write_data;
    logic [7:0]  bus_status;
    logic [7:0]  bus_read_data;
  } item_t;

  typedef struct packed {
    act_t       bus_action;
    logic [7:0] bus_byte;
    logic       done_res;
    logic       success;
    logic [7:0] read_data;
    logic       busy_res;
  } res_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [15:0] wait_limit;
    logic [9:0]  poll_limit;
  } cfg_t;

endpackage

>>> sv/i2cee_seq.sv
// Transaction state machine: state registers and one-word next-state logic.
module i2cee_seq #(
  parameter int unsigned ADDR_BITS = i2cee_pkg::ADDR_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  i2cee_pkg::item_t item,
  input  i2cee_pkg::cfg_t  cfg,
  output i2cee_pkg::res_t  res
);
  import i2cee_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic                   is_read_r, is_read_nxt;
  logic [ADDR_BITS-1:0]   held_addr_r, held_addr_nxt;
  logic [7:0]             held_wbyte_r, held_wbyte_nxt;
  logic [15:0]            wait_cnt_r, wait_cnt_nxt;
  logic [9:0]             poll_cnt_r, poll_cnt_nxt;
  logic [7:0]             capt_r, capt_nxt;

  logic [7:0]  st;
  logic [7:0]  sla_w;
  logic [15:0] addr16;
  logic [15:0] wait_inc;
  logic [9:0]  poll_inc;
  logic        start_ok;
  logic        do_issue, do_fail, do_finish, fin_ok, do_poll;
  phase_t      iss_phase;
  act_t        iss_act;
  logic [7:0]  iss_byte;

  assign st       = {item.bus_status[7:3], 3'b000};
  assign sla_w    = {cfg.device_address, 1'b0};
  assign addr16   = 16'(held_addr_r);
  assign wait_inc = wait_cnt_r + 16'd1;
  assign poll_inc = poll_cnt_r + 10'd1;
  assign start_ok = (st == ST_START) || (st == ST_RSTART);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      is_read_r    <= 1'b0;
      held_addr_r  <= '0;
      held_wbyte_r <= '0;
      wait_cnt_r   <= '0;
      poll_cnt_r   <= '0;
      capt_r       <= '0;
    end else begin
      phase_r      <= phase_nxt;
      is_read_r    <= is_read_nxt;
      held_addr_r  <= held_addr_nxt;
      held_wbyte_r <= held_wbyte_nxt;
      wait_cnt_r   <= wait_cnt_nxt;
      poll_cnt_r   <= poll_cnt_nxt;
      capt_r       <= capt_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    is_read_nxt    = is_read_r;
    held_addr_nxt  = held_addr_r;
    held_wbyte_nxt = held_wbyte_r;
    wait_cnt_nxt   = wait_cnt_r;
    poll_cnt_nxt   = poll_cnt_r;
    capt_nxt       = capt_r;
    do_issue       = 1'b0;
    do_fail        = 1'b0;
    do_finish      = 1'b0;
    fin_ok         = 1'b0;
    do_poll        = 1'b0;
    iss_phase      = PH_IDLE;
    iss_act        = ACT_NONE;
    iss_byte       = 8'h00;
    res            = '0;

    if (step) begin
      if (phase_r == PH_IDLE) begin
        if (item.command == CMD_WRITE || item.command == CMD_READ) begin
          is_read_nxt = (item.command == CMD_READ);
          if ((item.mem_address >> ADDR_BITS) != 16'd0) begin
            do_finish = 1'b1;
          end else begin
            held_addr_nxt  = item.mem_address[ADDR_BITS-1:0];
            held_wbyte_nxt = item.write_data;
            poll_cnt_nxt   = '0;
            do_issue       = 1'b1;
            iss_phase      = PH_START;
            iss_act        = ACT_START;
          end
        end
      end else if (item.command == CMD_EVENT) begin
        unique case (phase_r)
          PH_START, PH_P_START: begin
            if (start_ok) begin
              do_issue  = 1'b1;
              iss_phase = (phase_r == PH_START) ? PH_SLA_W : PH_P_SLA;
              iss_act   = ACT_BYTE;
              iss_byte  = sla_w;
            end else begin
              do_fail = 1'b1;
            end
          end
          PH_SLA_W: begin
            if (st == ST_SLA_W_ACK) begin
              do_issue  = 1'b1;
              iss_phase = PH_ADDR_HI;
              iss_act   = ACT_BYTE;
              iss_byte  = addr16[15:8];
            end else begin
              do_fail = 1'b1;
            end
          end
          PH_ADDR_HI: begin
            if (st == ST_DATA_ACK) begin
              do_issue  = 1'b1;
              iss_phase = PH_ADDR_LO;
              iss_act   = ACT_BYTE;
              iss_byte  = addr16[7:0];
            end else begin
              do_fail = 1'b1;
            end
          end
          PH_ADDR_LO: begin
            if (st != ST_DATA_ACK) begin
              do_fail = 1'b1;
            end else if (is_read_r) begin
              do_issue  = 1'b1;
              iss_phase = PH_RSTART;
              iss_act   = ACT_START;
            end else begin
              do_issue  = 1'b1;
              iss_phase = PH_DATA;
              iss_act   = ACT_BYTE;
              iss_byte  = held_wbyte_r;
            end
          end
          PH_DATA: begin
            if (st == ST_DATA_ACK) begin
              do_issue  = 1'b1;
              iss_phase = PH_STOP_W;
              iss_act   = ACT_STOP;
            end else begin
              do_fail = 1'b1;
            end
          end
          PH_STOP_W: begin
            poll_cnt_nxt = '0;
            do_issue     = 1'b1;
            iss_phase    = PH_P_START;
            iss_act      = ACT_START;
          end
          PH_RSTART: begin
            if (start_ok) begin
              do_issue  = 1'b1;
              iss_phase = PH_SLA_R;
              iss_act   = ACT_BYTE;
              iss_byte  = sla_w | 8'h01;
            end else begin
              do_fail = 1'b1;
            end
          end
          PH_SLA_R: begin
            if (st == ST_SLA_R_ACK) begin
              do_issue  = 1'b1;
              iss_phase = PH_READ;
              iss_act   = ACT_READ;
            end else begin
              do_fail = 1'b1;
            end
          end
          PH_READ: begin
            if (st == ST_READ_NAK) begin
              capt_nxt  = item.bus_read_data;
              do_issue  = 1'b1;
              iss_phase = PH_STOP_OK;
              iss_act   = ACT_STOP;
            end else begin
              do_fail = 1'b1;
            end
          end
          PH_STOP_OK: begin
            do_finish = 1'b1;
            fin_ok    = 1'b1;
          end
          PH_P_SLA: begin
            if (st == ST_SLA_W_ACK) begin
              do_issue  = 1'b1;
              iss_phase = PH_STOP_OK;
              iss_act   = ACT_STOP;
            end else if (st == ST_SLA_W_NAK) begin
              do_issue  = 1'b1;
              iss_phase = PH_P_RETRY;
              iss_act   = ACT_STOP;
            end else begin
              do_fail = 1'b1;
            end
          end
          PH_P_RETRY: do_poll = 1'b1;
          default:    do_finish = 1'b1;
        endcase
      end else if (item.command == CMD_TICK) begin
        wait_cnt_nxt = wait_inc;
        if (wait_inc >= cfg.wait_limit) begin
          unique case (phase_r)
            PH_STOP_W, PH_STOP_OK, PH_STOP_FAIL: do_finish = 1'b1;
            PH_P_RETRY:                          do_poll   = 1'b1;
            default:                             do_fail   = 1'b1;
          endcase
        end
      end

      // poll attempt bookkeeping
      if (do_poll) begin
        poll_cnt_nxt = poll_inc;
        if (poll_inc >= cfg.poll_limit) begin
          do_finish = 1'b1;
        end else begin
          do_issue  = 1'b1;
          iss_phase = PH_P_START;
          iss_act   = ACT_START;
        end
      end

      if (do_fail) begin
        do_issue  = 1'b1;
        iss_phase = PH_STOP_FAIL;
        iss_act   = ACT_STOP;
        iss_byte  = 8'h00;
      end

      if (do_issue) begin
        phase_nxt      = iss_phase;
        wait_cnt_nxt   = '0;
        res.bus_action = iss_act;
        res.bus_byte   = iss_byte;
      end else if (do_finish) begin
        phase_nxt     = PH_IDLE;
        wait_cnt_nxt  = '0;
        res.done_res  = 1'b1;
        res.success   = fin_ok;
        res.read_data = (fin_ok && is_read_r) ? capt_r : 8'h00;
      end
    end

    res.busy_res = (phase_nxt != PH_IDLE);
  end

endmodule

>>> sv/i2c_eeprom_byte_access_sequencer_core.sv
// Top level: stream ports, configuration registers, input and result registers.
//
// Sequences one-byte writes and random reads of a 24C64-class EEPROM over a
// byte-level I2C master. Every input word (tuser = command) gives exactly one
// result word: the next bus action and byte, and done/success/read data.
// Requests: write or read with a memory address; addresses beyond ADDR_BITS
// finish at once with success low. Bus events carry the engine's status and
// read byte; ticks drive the wait timeout. After a write the block polls the
// device with address-only attempts until it acknowledges or poll_limit runs
// out.
// The input register loads at the accepting edge; the state update and result
// register load from it once the result register is free to take a word.
// Throughput: one word per clock while out_tready stays high; the single
// next-state pass of the phase machine sets this figure.
// When out_tready is low the result register holds and the input register
// still takes one more word; in_tready falls only when both are full.
// Reset (rst_n low, synchronous) returns to idle and loads the register
// defaults: device address 0x50, wait limit 60000, poll limit 1000.
// Configuration writes are always ready and take effect on the next word.
module i2c_eeprom_byte_access_sequencer_core #(
  parameter int unsigned ADDR_BITS = i2cee_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // mem_address[15:0], write_data[23:16],
                                  // bus_status[31:24], bus_read_data[39:32]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // bus_byte[7:0], done_res[8], success[9],
                                  // read_data[17:10], busy_res[18], zero[23:19]
  output logic [2:0]  out_tuser,  // bus_action[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import i2cee_pkg::*;

  logic  s1_v_r;
  item_t s1_item_r;
  logic  out_v_r;
  res_t  out_res_r;
  cfg_t  cfg_r;
  res_t  res;
  logic  advance;

  assign advance   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= DEV_ADDR_RST;
      cfg_r.wait_limit     <= WAIT_LIMIT_RST;
      cfg_r.poll_limit     <= POLL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEV_ADDR:   cfg_r.device_address <= cfg_data[6:0];
        CFG_WAIT_LIMIT: cfg_r.wait_limit     <= cfg_data;
        CFG_POLL_LIMIT: cfg_r.poll_limit     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.command       <= cmd_t'(in_tuser);
      s1_item_r.mem_address   <= in_tdata[15:0];
      s1_item_r.write_data    <= in_tdata[23:16];
      s1_item_r.bus_status    <= in_tdata[31:24];
      s1_item_r.bus_read_data <= in_tdata[39:32];
    end
  end

  i2cee_seq #(
    .ADDR_BITS (ADDR_BITS)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.bus_action;
  assign out_tdata  = {5'b00000, out_res_r.busy_res, out_res_r.read_data,
                       out_res_r.success, out_res_r.done_res, out_res_r.bus_byte};

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("processed word did not reach the result register");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.done_res) |-> !out_res_r.busy_res)
    else $error("finished request still reports busy");

  a_success_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.success) |-> out_res_r.done_res)
    else $error("success without done");

  a_byte_only_send: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.bus_action != ACT_BYTE) |-> (out_res_r.bus_byte == 8'h00))
    else $error("bus byte set without a send action");

endmodule
